[rtl/core/rbhd_pkg.sv]
`default_nettype none

package rbhd_pkg;

  // Configuration register fields are 13 bits wide.
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 1'b0,
    CFG_SRC_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam logic [CFG_DATA_W-1:0] SRC_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] SRC_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Horizontal pair sums, one 9-bit value per channel.
  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } sum_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } tag_t;

  typedef struct packed {
    logic valid;
    sum_t sum;
    tag_t tag;
  } stage_t;

endpackage

`default_nettype wire

[rtl/core/rbhd_line_buf.sv]
`default_nettype none

module rbhd_line_buf #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     addr_i,
  input  wire rbhd_pkg::sum_t    wdata_i,
  output rbhd_pkg::sum_t         rdata_o
);
  import rbhd_pkg::*;

  sum_t mem_q [DEPTH];
  sum_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/rbhd_ctrl.sv]
`default_nettype none

module rbhd_ctrl #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned AW        = 11
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rbhd_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  wire logic [rbhd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                accept_i,
  input  wire rbhd_pkg::pix_t                      pix_i,
  input  wire logic                                s1_open_i,
  output logic                                     mem_we_o,
  output logic                                     mem_re_o,
  output logic [AW-1:0]                            mem_addr_o,
  output rbhd_pkg::sum_t                           mem_wdata_o,
  output rbhd_pkg::stage_t                         s1_o
);
  import rbhd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_WIDTH);
  localparam int unsigned SZ_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW    = (SZ_W > CFG_DATA_W) ? SZ_W : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic [CNT_W-1:0]      col_q, col_d, row_q, row_d;
  pix_t                  held_q;
  stage_t                s1_q, s1_d;

  logic [CW-1:0] w_raw, h_raw, w_sz, h_sz, half_w, half_h;
  logic [CW-1:0] col_ext, row_ext, pair, row_pair;
  logic          odd_col, in_range, emit, row_end, frame_end;
  sum_t          sum;

  always_comb begin
    w_raw = CW'(width_q);
    h_raw = CW'(height_q);
    if (w_raw == '0) begin
      w_sz = CW'(1);
    end else if (w_raw > CW'(MAX_WIDTH)) begin
      w_sz = CW'(MAX_WIDTH);
    end else begin
      w_sz = w_raw;
    end
    if (h_raw == '0) begin
      h_sz = CW'(1);
    end else if (h_raw > CW'(MAX_WIDTH)) begin
      h_sz = CW'(MAX_WIDTH);
    end else begin
      h_sz = h_raw;
    end
    half_w   = w_sz >> 1;
    half_h   = h_sz >> 1;
    col_ext  = CW'(col_q);
    row_ext  = CW'(row_q);
    pair     = col_ext >> 1;
    row_pair = row_ext >> 1;
  end

  // The right pixel of a pair completes the horizontal sum.
  always_comb begin
    odd_col   = col_q[0];
    in_range  = odd_col && (pair < half_w);
    sum.red   = {1'b0, held_q.red}   + {1'b0, pix_i.red};
    sum.green = {1'b0, held_q.green} + {1'b0, pix_i.green};
    sum.blue  = {1'b0, held_q.blue}  + {1'b0, pix_i.blue};
    emit      = in_range && row_q[0] && (row_pair < half_h);
    row_end   = (pair == half_w - CW'(1));
    frame_end = row_end && (row_pair == half_h - CW'(1));
  end

  assign mem_we_o    = accept_i && in_range && !row_q[0];
  assign mem_re_o    = accept_i && emit;
  assign mem_addr_o  = pair[AW-1:0];
  assign mem_wdata_o = sum;

  // Raster counters wrap at the clamped frame size.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_ext + CW'(1) >= w_sz) begin
      col_d = '0;
      if (row_ext + CW'(1) >= h_sz) begin
        row_d = '0;
      end else begin
        row_d = row_q + CNT_W'(1);
      end
    end else begin
      col_d = col_q + CNT_W'(1);
    end
  end

  always_comb begin
    s1_d = s1_q;
    if (s1_open_i) begin
      s1_d.valid         = accept_i && emit;
      s1_d.sum           = sum;
      s1_d.tag.row_end   = row_end;
      s1_d.tag.frame_end = frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SRC_WIDTH_RST;
      height_q <= SRC_HEIGHT_RST;
      col_q    <= '0;
      row_q    <= '0;
      held_q   <= '0;
      s1_q     <= '0;
    end else begin
      s1_q <= s1_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_addr_i))
          CFG_SRC_WIDTH:  width_q  <= cfg_data_i;
          CFG_SRC_HEIGHT: height_q <= cfg_data_i;
          default:        width_q  <= width_q;
        endcase
        col_q <= '0;
        row_q <= '0;
      end else if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
        if (!odd_col) begin
          held_q <= pix_i;
        end
      end
    end
  end

  assign s1_o = s1_q;

endmodule

`default_nettype wire

[rtl/core/rbhd_avg.sv]
`default_nettype none

module rbhd_avg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rbhd_pkg::stage_t s1_i,
  input  wire rbhd_pkg::sum_t   line_i,
  input  wire logic             out_ready_i,
  output logic                  valid_o,
  output rbhd_pkg::pix_t        pix_o,
  output rbhd_pkg::tag_t        tag_o
);
  import rbhd_pkg::*;

  logic       valid_q;
  pix_t       pix_q, pix_d;
  tag_t       tag_q;
  logic [9:0] tot_r, tot_g, tot_b;

  // Four-sample sum, then divide by four with truncation.
  always_comb begin
    tot_r       = {1'b0, s1_i.sum.red}   + {1'b0, line_i.red};
    tot_g       = {1'b0, s1_i.sum.green} + {1'b0, line_i.green};
    tot_b       = {1'b0, s1_i.sum.blue}  + {1'b0, line_i.blue};
    pix_d.red   = tot_r[9:2];
    pix_d.green = tot_g[9:2];
    pix_d.blue  = tot_b[9:2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_ready_i) begin
      valid_q <= s1_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i) begin
      pix_q <= pix_d;
      tag_q <= s1_i.tag;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire

[rtl/core/rgb_box_halving_downscaler.sv]
// Channel      | Direction | Word contents (lowest bit first)
// s_axis_*     | in        | tdata: red[7:0], green[15:8], blue[23:16]
// m_axis_*     | out       | tdata: red, green, blue; tlast: row end; tuser: frame end
// cfg_*        | in        | we, register index, 13-bit value (0: width, 1: height)
//
// Throughput is one source pixel per clock unless the input stalls. The input word that
// completes a 2x2 block passes the stage register, then the result register, to the output.
// Reset sets 640 by 480, clears the counters, the held pixel and both valid bits;
// the line buffer is not cleared, as each odd row reads only what its even row wrote.
// A stalled output holds its word while one more result waits in the stage
// register; the input side stalls only when both are full.
`default_nettype none

module rgb_box_halving_downscaler #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [23:0]                       s_axis_tdata,  // red, green, blue
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [23:0]                            m_axis_tdata,  // red, green, blue
  output logic                                   m_axis_tlast,  // row_end
  output logic [0:0]                             m_axis_tuser,  // frame_end
  input  wire logic                              cfg_we_i,
  input  wire logic [rbhd_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  wire logic [rbhd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import rbhd_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH / 2;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic       accept, out_ready, s1_open;
  logic       mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  sum_t       mem_wdata, mem_rdata;
  stage_t     s1;
  pix_t       in_pix, out_pix;
  tag_t       out_tag;

  // The result register frees up when empty or taken; the stage register
  // behind it then frees up too, which is what lets a new word in.
  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign s1_open       = !s1.valid || out_ready;
  assign s_axis_tready = s1_open;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_pix.red   = s_axis_tdata[7:0];
  assign in_pix.green = s_axis_tdata[15:8];
  assign in_pix.blue  = s_axis_tdata[23:16];

  rbhd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .pix_i       (in_pix),
    .s1_open_i   (s1_open),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .s1_o        (s1)
  );

  // Even rows write pair sums, odd rows read them back for the same pair.
  rbhd_line_buf #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  rbhd_avg u_avg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_i        (s1),
    .line_i      (mem_rdata),
    .out_ready_i (out_ready),
    .valid_o     (m_axis_tvalid),
    .pix_o       (out_pix),
    .tag_o       (out_tag)
  );

  assign m_axis_tdata = {out_pix.blue, out_pix.green, out_pix.red};
  assign m_axis_tlast = out_tag.row_end;
  assign m_axis_tuser = out_tag.frame_end;

endmodule

`default_nettype wire

[rtl/core/rbhd_checker.sv]
`default_nettype none

module rbhd_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [23:0]                       m_axis_tdata,
  input wire logic                              m_axis_tlast,
  input wire logic [0:0]                        m_axis_tuser
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // The last word of a frame is also the last word of its row.
  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("frame end without row end");

  // Into an empty output, a word arrives once its input has passed the stage and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_acc, 2))
    else $error("output word without matching input word");

  // A stalled output word holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output word changed under stall");

endmodule

bind rgb_box_halving_downscaler rbhd_checker u_rbhd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
